// ----- rtl/core/tsei_pkg.sv -----
package tsei_pkg;

  // Widths of the fields on the ports.
  localparam int FIELD_W = 32;
  localparam int POINTS_W = 16;
  localparam int EXP_W = 4;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCTION_ONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCTION_TWO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ONE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TWO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_ONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_TWO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HILL_EXPONENT = 3'd6;

  // Exponent limits and reset value.
  localparam logic [EXP_W-1:0] EXP_MIN = 4'd1;
  localparam logic [EXP_W-1:0] EXP_MAX = 4'd8;
  localparam logic [EXP_W-1:0] EXP_RESET = 4'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CONC_X,
    S_CONC_Y,
    S_STEP,
    S_POW,
    S_GAIN,
    S_LOSS,
    S_DELTA,
    S_OUT_X,
    S_OUT_Y,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/toggle_switch_euler_integrator.sv -----
// Forward Euler integrator for a two-gene mutual repression switch.
// Input channel: an item (two amounts, volume, time span, point count) is
// taken at a rising edge where start is high and busy is low. busy stays
// high until the result has been shown.
// Result: final_one, final_two and bad_request are valid for exactly one
// cycle while done is high. The receiver cannot stall the block.
// Configuration: cfg_ready is always high; cfg_valid writes a register.
// Writes must be made only while busy is low; the block does not check.
// Sequence: a bad request (fewer than two points or zero volume) shows its
// result in the cycle right after it is taken. Otherwise each item runs
// through one shared shift-and-add / shift-and-subtract unit (Q16.16 by
// default): three divides, then num_points Euler steps of each species,
// then two multiplies. One Euler step of one species costs (m+1)
// multiplies and one divide. The unit takes a new operation only once the
// last one has finished.
// Throughput: the next item can be taken in the cycle after the strobe.
// Reset: configuration registers return to 1.0 (exponent 2) and the block goes idle.
module toggle_switch_euler_integrator #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [tsei_pkg::FIELD_W-1:0]           amount_one,
  input  logic [tsei_pkg::FIELD_W-1:0]           amount_two,
  input  logic [tsei_pkg::FIELD_W-1:0]           volume,
  input  logic [tsei_pkg::FIELD_W-1:0]           time_span,
  input  logic [tsei_pkg::POINTS_W-1:0]          num_points,
  output logic                                   done,
  output logic [tsei_pkg::FIELD_W-1:0]           final_one,
  output logic [tsei_pkg::FIELD_W-1:0]           final_two,
  output logic                                   bad_request,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tsei_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tsei_pkg::FIELD_W-1:0]           cfg_data
);
  import tsei_pkg::*;

  localparam int W = WORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int DW = W + F;
  localparam int CNT_W = $clog2(DW + 1);
  localparam logic [W-1:0] VMAX = {W{1'b1}};
  localparam logic [W-1:0] ONE = W'(1) << F;

  // Configuration registers.
  logic [W-1:0] production_one, production_two, offset_one, offset_two;
  logic [W-1:0] decay_one, decay_two;
  logic [EXP_W-1:0] hill_exponent;

  // Request and working registers.
  state_t state, state_next;
  logic [W-1:0] vol, span, x, y, nx, step, pw, gain, loss;
  logic [W-1:0] a_one, a_two;
  logic [POINTS_W-1:0] pts, iter;
  logic [EXP_W-1:0] k;
  logic sp;

  // Shared arithmetic unit.
  logic u_run, u_fin, u_div, u_dz;
  logic [CNT_W-1:0] u_cnt;
  logic [W-1:0] hi, lo, mcand, rem;
  logic [DW-1:0] dvd, quo;
  logic go, op_div;
  logic [W-1:0] op_a, op_b;
  logic [DW-1:0] op_dvd;
  logic [W-1:0] res;
  logic [W-1:0] op_b_hold;

  // Species-dependent operands.
  logic [W-1:0] cur, rep, prod, offs, decay, den, nv, diff;
  logic [EXP_W-1:0] m_eff;
  logic [W:0] den_sum, up_sum;
  logic [W:0] mul_sum;
  logic [W:0] div_t;
  logic div_ge;
  logic [2*W-1:0] prod_full;
  logic err;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign err = (num_points < POINTS_W'(2)) || (volume == '0);

  // Exponent clamped to its legal range.
  always_comb begin
    if (hill_exponent < EXP_MIN) begin
      m_eff = EXP_MIN;
    end else if (hill_exponent > EXP_MAX) begin
      m_eff = EXP_MAX;
    end else begin
      m_eff = hill_exponent;
    end
  end

  // Operands of the species being updated.
  always_comb begin
    cur = sp ? y : x;
    rep = sp ? x : y;
    prod = sp ? production_two : production_one;
    offs = sp ? offset_two : offset_one;
    decay = sp ? decay_two : decay_one;
    den_sum = {1'b0, offs} + {1'b0, pw};
    den = den_sum[W] ? VMAX : den_sum[W-1:0];
    diff = (gain >= loss) ? (gain - loss) : (loss - gain);
    up_sum = {1'b0, cur} + {1'b0, res};
    if (gain >= loss) begin
      nv = up_sum[W] ? VMAX : up_sum[W-1:0];
    end else begin
      nv = (cur > res) ? (cur - res) : '0;
    end
  end

  // Result of the shared unit, saturated to the word.
  always_comb begin
    prod_full = {hi, lo};
    if (u_div) begin
      res = (u_dz || ((quo >> W) != '0)) ? VMAX : quo[W-1:0];
    end else begin
      res = ((prod_full >> DW) != '0) ? VMAX : prod_full[DW-1:F];
    end
  end

  // One step of the unit: add for multiply, compare and subtract for divide.
  always_comb begin
    mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
    div_t = {rem, dvd[DW-1]};
    div_ge = (div_t >= {1'b0, op_b_hold});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_run <= 1'b0;
      u_fin <= 1'b0;
    end else begin
      u_fin <= 1'b0;
      if (go) begin
        u_run <= 1'b1;
        u_cnt <= '0;
        u_div <= op_div;
        u_dz <= (op_b == '0);
        op_b_hold <= op_b;
        rem <= '0;
        dvd <= op_dvd;
        quo <= '0;
        hi <= '0;
        lo <= op_b;
        mcand <= op_a;
      end else if (u_run) begin
        u_cnt <= u_cnt + CNT_W'(1);
        if (u_div) begin
          dvd <= dvd << 1;
          quo <= {quo[DW-2:0], div_ge};
          rem <= div_ge ? W'(div_t - {1'b0, op_b_hold}) : div_t[W-1:0];
        end else begin
          hi <= mul_sum[W:1];
          lo <= {mul_sum[0], lo[W-1:1]};
        end
        if (u_cnt == (u_div ? CNT_W'(DW - 1) : CNT_W'(W - 1))) begin
          u_run <= 1'b0;
          u_fin <= 1'b1;
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = err ? S_DONE : S_CONC_X;
      end
      S_CONC_X: if (u_fin) state_next = S_CONC_Y;
      S_CONC_Y: if (u_fin) state_next = S_STEP;
      S_STEP: if (u_fin) state_next = S_POW;
      S_POW: if (k >= m_eff) state_next = S_GAIN;
      S_GAIN: if (u_fin) state_next = S_LOSS;
      S_LOSS: if (u_fin) state_next = S_DELTA;
      S_DELTA: begin
        if (u_fin) begin
          state_next = (sp && (iter == pts - POINTS_W'(1))) ? S_OUT_X : S_POW;
        end
      end
      S_OUT_X: if (u_fin) state_next = S_OUT_Y;
      S_OUT_Y: if (u_fin) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Launch of the shared unit and the result strobe.
  always_comb begin
    go = 1'b0;
    op_div = 1'b0;
    op_a = '0;
    op_b = '0;
    op_dvd = '0;
    done = (state == S_DONE);
    case (state)
      S_CONC_X: begin
        op_div = 1'b1;
        op_dvd = {a_one, F'(0)};
        op_b = vol;
      end
      S_CONC_Y: begin
        op_div = 1'b1;
        op_dvd = {a_two, F'(0)};
        op_b = vol;
      end
      S_STEP: begin
        op_div = 1'b1;
        op_dvd = DW'(span);
        op_b = W'(pts - POINTS_W'(1));
      end
      S_POW: begin
        op_a = pw;
        op_b = rep;
      end
      S_GAIN: begin
        op_div = 1'b1;
        op_dvd = {prod, F'(0)};
        op_b = den;
      end
      S_LOSS: begin
        op_a = decay;
        op_b = cur;
      end
      S_DELTA: begin
        op_a = step;
        op_b = diff;
      end
      S_OUT_X: begin
        op_a = x;
        op_b = vol;
      end
      S_OUT_Y: begin
        op_a = y;
        op_b = vol;
      end
      default: begin
        op_a = '0;
      end
    endcase
    if ((state != S_IDLE) && (state != S_DONE) && !u_run && !u_fin) begin
      go = (state != S_POW) || (k < m_eff);
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      production_one <= ONE;
      production_two <= ONE;
      offset_one <= ONE;
      offset_two <= ONE;
      decay_one <= ONE;
      decay_two <= ONE;
      hill_exponent <= EXP_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_PRODUCTION_ONE: production_one <= W'(cfg_data);
          REG_PRODUCTION_TWO: production_two <= W'(cfg_data);
          REG_OFFSET_ONE: offset_one <= W'(cfg_data);
          REG_OFFSET_TWO: offset_two <= W'(cfg_data);
          REG_DECAY_ONE: decay_one <= W'(cfg_data);
          REG_DECAY_TWO: decay_two <= W'(cfg_data);
          REG_HILL_EXPONENT: hill_exponent <= cfg_data[EXP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers of the integration.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          a_one <= W'(amount_one);
          a_two <= W'(amount_two);
          vol <= W'(volume);
          span <= W'(time_span);
          pts <= num_points;
          bad_request <= err;
          final_one <= '0;
          final_two <= '0;
        end
      end
      S_CONC_X: if (u_fin) x <= res;
      S_CONC_Y: if (u_fin) y <= res;
      S_STEP: begin
        if (u_fin) begin
          step <= res;
          sp <= 1'b0;
          iter <= '0;
          pw <= y;
          k <= EXP_MIN;
        end
      end
      S_POW: begin
        if (u_fin) begin
          pw <= res;
          k <= k + EXP_W'(1);
        end
      end
      S_GAIN: if (u_fin) gain <= res;
      S_LOSS: if (u_fin) loss <= res;
      S_DELTA: begin
        if (u_fin) begin
          k <= EXP_MIN;
          if (!sp) begin
            nx <= nv;
            sp <= 1'b1;
            pw <= x;
          end else begin
            x <= nx;
            y <= nv;
            sp <= 1'b0;
            pw <= nv;
            iter <= iter + POINTS_W'(1);
          end
        end
      end
      S_OUT_X: if (u_fin) final_one <= FIELD_W'(res);
      S_OUT_Y: if (u_fin) final_two <= FIELD_W'(res);
      default: ;
    endcase
  end

  // The block returns to idle right after showing a result.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");

  // An accepted item makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");

  // A bad request reports zero amounts.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (done && bad_request) |-> (final_one == '0 && final_two == '0))
    else $error("bad request with nonzero result");

  // The unit only finishes after running.
  a_fin_run: assert property (@(posedge clk) disable iff (rst)
    u_fin |-> $past(u_run)) else $error("unit finished without running");

  // The unit is never launched while it runs.
  a_no_relaunch: assert property (@(posedge clk) disable iff (rst)
    u_run |-> !go) else $error("unit launched while running");

endmodule
